@@ rtl/spq_pkg.sv @@
// Package for the sorted priority queue: operation codes, payload types and
// the cell control structure. It has no dependencies.
package spq_pkg;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    typedef logic signed [15:0] t_prio;
    typedef logic signed [31:0] t_value;
    typedef logic [4:0]         t_entry_count;

    typedef struct packed {
        t_prio  prio;
        t_value value;
    } t_entry;

    typedef struct packed {
        logic push_en;
        logic pop_en;
    } t_cell_ctrl;

endpackage

@@ rtl/spq_in_if.sv @@
// Input channel of the sorted priority queue: valid, ready and one request.
// It depends on spq_pkg.
interface spq_in_if;
    import spq_pkg::*;

    logic   valid;
    logic   ready;
    t_func  func;
    t_prio  priority_req;
    t_value value;

    modport source (output valid, func, priority_req, value, input ready);
    modport sink (input valid, func, priority_req, value, output ready);
endinterface

@@ rtl/spq_out_if.sv @@
// Output channel of the sorted priority queue: valid, ready and one result.
// It depends on spq_pkg.
interface spq_out_if;
    import spq_pkg::*;

    logic         valid;
    logic         ready;
    t_value       popped_value;
    logic         was_empty;
    logic         dropped;
    t_entry_count entry_count;

    modport source (output valid, popped_value, was_empty, dropped, entry_count, input ready);
    modport sink (input valid, popped_value, was_empty, dropped, entry_count, output ready);
endinterface

@@ rtl/spq_cell.sv @@
// One storage cell of the sorted priority queue chain. It holds one entry and
// takes its next contents from its left or right neighbour or from a push.
// It depends on spq_pkg.
module spq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_entry     i_new,
    input  logic [CNT_W-1:0]    i_count,
    input  spq_pkg::t_entry     i_left,
    input  logic                i_left_ins,
    input  spq_pkg::t_entry     i_right,
    output spq_pkg::t_entry     o_entry,
    output logic                o_ins
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_valid;

    assign w_valid = (CNT_W'(IDX) < i_count);
    assign o_ins   = !w_valid || ($signed(i_new.prio) > $signed(r_entry.prio));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push_en) begin
            if (i_left_ins) begin
                n_entry = i_left;
            end else if (o_ins) begin
                n_entry = i_new;
            end
        end else if (i_ctrl.pop_en) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end
endmodule

@@ rtl/sorted_priority_queue.sv @@
// Sorted priority queue built as a chain of CAPACITY cells.
// The result of a transaction is registered and shown in the cycle after it is accepted.
// Throughput: one push or pop per cycle while results are taken; every cell compares and shifts in parallel.
// A new transaction is taken whenever the output register is empty or being emptied.
// Reset clears the entry count and the output valid; stored entries are not cleared.
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spq_in_if.sink        i_in,
    spq_out_if.source     o_out
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_value           r_popped_value;
    logic             r_was_empty;
    logic             r_dropped;
    t_entry_count     r_entry_count;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_is_pop;
    t_cell_ctrl       w_ctrl;
    t_entry           w_new;
    logic [CNT_W+4:0] w_count_ext;

    t_entry           w_cell_entry [CAPACITY];
    logic             w_cell_ins   [CAPACITY];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_is_pop   = (i_in.func == FUNC_POP);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    assign w_ctrl.push_en = w_accept && !w_is_pop && !w_full;
    assign w_ctrl.pop_en  = w_accept && w_is_pop && !w_empty;
    assign w_new.prio     = i_in.priority_req;
    assign w_new.value    = i_in.value;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_entry w_left;
            logic   w_left_ins;
            t_entry w_right;

            if (g == 0) begin : g_first
                assign w_left     = '0;
                assign w_left_ins = 1'b0;
            end else begin : g_inner_left
                assign w_left     = w_cell_entry[g-1];
                assign w_left_ins = w_cell_ins[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner_right
                assign w_right = w_cell_entry[g+1];
            end

            spq_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_new      (w_new),
                .i_count    (r_count),
                .i_left     (w_left),
                .i_left_ins (w_left_ins),
                .i_right    (w_right),
                .o_entry    (w_cell_entry[g]),
                .o_ins      (w_cell_ins[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctrl.push_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pop_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_count_ext = {5'b00000, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_popped_value <= w_ctrl.pop_en ? w_cell_entry[0].value : '0;
            r_was_empty    <= w_is_pop && w_empty;
            r_dropped      <= !w_is_pop && w_full;
            r_entry_count  <= w_count_ext[4:0];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_popped_value;
    assign o_out.was_empty    = r_was_empty;
    assign o_out.dropped      = r_dropped;
    assign o_out.entry_count  = r_entry_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds the capacity.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_was_empty && r_dropped))
        else $error("A result reports both an empty pop and a dropped push.");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.push_en |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("An accepted push did not add one entry.");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop_en |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("An accepted pop did not remove one entry.");

    generate
        for (g = 0; g < CAPACITY - 1; g++) begin : g_order_chk
            a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (r_count > CNT_W'(g + 1)) |->
                ($signed(w_cell_entry[g].prio) >= $signed(w_cell_entry[g+1].prio)))
                else $error("Adjacent entries are out of priority order.");
        end
    endgenerate
endmodule

@@ sim/tb_sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue: directed and random push and pop traffic with a
// shadow queue that predicts every result. It depends on spq_pkg, spq_in_if and spq_out_if.
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned BLOCK_ITEMS = 100;
    localparam int unsigned BLOCK_COUNT = 16;

    typedef struct packed {
        t_value       popped_value;
        logic         was_empty;
        logic         dropped;
        t_entry_count entry_count;
    } t_queue_result;

    class spq_tracker;
        int unsigned   capacity;
        t_entry        shadow_entries[$];
        t_queue_result awaited[$];
        int unsigned   mismatches;
        int unsigned   pushes;
        int unsigned   refused;
        int unsigned   pops;
        int unsigned   empty_pops;
        int unsigned   peak_fill;

        function new(int unsigned cap);
            capacity = cap;
        endfunction

        function t_queue_result apply_request(t_func op, t_prio prio, t_value value);
            t_queue_result r;
            t_entry        e;
            int            slot;
            r = '0;
            if (op == FUNC_PUSH) begin
                pushes++;
                if (shadow_entries.size() >= capacity) begin
                    r.dropped = 1'b1;
                    refused++;
                end else begin
                    slot = 0;
                    while (slot < shadow_entries.size() &&
                           !(prio > $signed(shadow_entries[slot].prio)))
                        slot++;
                    e.prio  = prio;
                    e.value = value;
                    if (slot == shadow_entries.size())
                        shadow_entries.push_back(e);
                    else
                        shadow_entries.insert(slot, e);
                end
            end else begin
                pops++;
                if (shadow_entries.size() == 0) begin
                    r.was_empty = 1'b1;
                    empty_pops++;
                end else begin
                    e = shadow_entries.pop_front();
                    r.popped_value = e.value;
                end
            end
            if (shadow_entries.size() > peak_fill)
                peak_fill = shadow_entries.size();
            r.entry_count = t_entry_count'(shadow_entries.size());
            return r;
        endfunction

        function void note_request(t_func op, t_prio prio, t_value value);
            awaited.push_back(apply_request(op, prio, value));
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_queue_result got);
            t_queue_result want;
            if (awaited.size() == 0) begin
                $display("%0t: result with none awaited, expected nothing, actual %0h",
                         $time, got);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("popped_value", want.popped_value, got.popped_value);
            compare_field("was_empty", want.was_empty, got.was_empty);
            compare_field("dropped", want.dropped, got.dropped);
            compare_field("entry_count", want.entry_count, got.entry_count);
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    bit          steady = 1'b0;
    int unsigned cycle_count = 0;
    spq_tracker  tracker = new(QUEUE_DEPTH);

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run timed out", $time);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(99) >= 29);
    end

    always @(posedge i_clk) begin : monitor
        t_queue_result seen;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                seen = {out_ch.popped_value, out_ch.was_empty, out_ch.dropped,
                        out_ch.entry_count};
                tracker.check_result(seen);
            end
            if (in_ch.valid && in_ch.ready)
                tracker.note_request(in_ch.func, in_ch.priority_req, in_ch.value);
        end
    end

    task automatic send_item(t_func op, t_prio prio, t_value value);
        while (!steady && $urandom_range(99) < 29) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= op;
        in_ch.priority_req <= prio;
        in_ch.value        <= value;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_pop();
        send_item(FUNC_POP, t_prio'($urandom()), t_value'($urandom()));
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (tracker.pending() != 0);
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned push_pct;
        bit          narrow;
        t_prio       prio;

        in_ch.valid        = 1'b0;
        in_ch.func         = FUNC_PUSH;
        in_ch.priority_req = '0;
        in_ch.value        = '0;
        out_ch.ready       = 1'b0;
        i_rst_n            = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pop, extreme priorities and values, ties, a refused push when full, then pops.
        send_pop();
        send_item(FUNC_PUSH, 16'sd0, 32'h0000_0000);
        send_item(FUNC_PUSH, 16'sh7FFF, 32'h7FFF_FFFF);
        send_item(FUNC_PUSH, 16'sh8000, 32'h8000_0000);
        send_item(FUNC_PUSH, 16'sd0, 32'hFFFF_FFFF);
        send_item(FUNC_PUSH, -16'sd1, 32'h0000_0001);
        send_item(FUNC_PUSH, 16'sh7FFF, 32'h0000_0002);
        send_item(FUNC_PUSH, 16'sh8000, 32'h0000_0003);
        send_item(FUNC_PUSH, 16'sd1, 32'hA5A5_A5A5);
        send_item(FUNC_PUSH, 16'sd0, 32'h5A5A_5A5A);
        for (int k = 10; k <= 16; k++)
            send_item(FUNC_PUSH, t_prio'(k - 12), t_value'(k));
        send_item(FUNC_PUSH, 16'sd100, 32'hDEAD_BEEF);
        repeat (4) send_pop();
        wait_for_results();

        for (int unsigned b = 0; b < BLOCK_COUNT; b++) begin
            case ($urandom_range(2))
                0: push_pct = 20;
                1: push_pct = 50;
                default: push_pct = 80;
            endcase
            narrow = $urandom_range(1);
            steady = (b >= 6 && b < 9);
            for (int unsigned n = 0; n < BLOCK_ITEMS; n++) begin
                if ($urandom_range(99) < push_pct) begin
                    if (narrow)
                        prio = t_prio'($urandom_range(4)) - 16'sd2;
                    else
                        prio = t_prio'($urandom());
                    send_item(FUNC_PUSH, prio, t_value'($urandom()));
                end else begin
                    send_pop();
                end
            end
            if (b % 4 == 3)
                wait_for_results();
        end
        steady = 1'b0;

        wait_for_results();
        repeat (4) @(posedge i_clk);
        $display("summary: %0d pushes with %0d refused as full, %0d pops with %0d on an empty queue",
                 tracker.pushes, tracker.refused, tracker.pops, tracker.empty_pops);
        $display("summary: deepest fill %0d of %0d entries, %0d mismatches",
                 tracker.peak_fill, QUEUE_DEPTH, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
